// ===== hw/rtl/kli_pkg.sv =====
package kli_pkg;

    localparam int MAX_KEYS_DEF      = 64;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int KEY_COUNT_W       = 7;
    localparam int KEY_INDEX_W       = 6;
    localparam int DATA_W            = 32;

    // input command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // result kind codes
    localparam logic [1:0] CASE_FIRST  = 2'd0;
    localparam logic [1:0] CASE_INTERP = 2'd1;
    localparam logic [1:0] CASE_LAST   = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ0,
        ST_WAIT0,
        ST_CHECK0,
        ST_READ_PAIR,
        ST_WAIT_PAIR,
        ST_CHECK_PAIR,
        ST_DIVIDE,
        ST_MULTIPLY,
        ST_SCALE,
        ST_OUTPUT
    } kli_state_t;

    // controller to datapath
    typedef struct packed {
        logic load_query;    // capture query time and key count
        logic rd_first;      // read address 0
        logic rd_pair;       // read scan index and index + 1
        logic rd_last;       // read last key in use
        logic advance;       // scan index increments
        logic div_start;     // start fraction divide
        logic div_step;      // one divide step
        logic mul_go;        // register products
        logic scale_go;      // register scaled results
        logic load_out;      // load result register
        logic [1:0] which_case;
        logic out_from_lerp; // result from interpolation, else from port 0 read
    } kli_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic single;        // only one key in use
        logic before_first;  // query at or before key 0
        logic hit;           // current pair encloses query
        logic last_pair;     // current pair is the last one
        logic div_done;      // divide finished
    } kli_status_t;

endpackage

// ===== hw/rtl/kli_ram.sv =====
module kli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ===== hw/rtl/kli_ctrl.sv =====
module kli_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic                s_cmd,
    output logic                s_tready,
    input  logic                out_busy,
    input  kli_pkg::kli_status_t status,
    output kli_pkg::kli_cmd_t    cmd
);
    import kli_pkg::*;

    kli_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && s_cmd == CMD_QUERY)
                begin
                    state_next = ST_READ0;
                end
            end
            ST_READ0:  state_next = ST_WAIT0;
            ST_WAIT0:  state_next = ST_CHECK0;
            ST_CHECK0:
            begin
                if (status.single || status.before_first)
                begin
                    state_next = ST_OUTPUT;
                end
                else
                begin
                    state_next = ST_READ_PAIR;
                end
            end
            ST_READ_PAIR: state_next = ST_WAIT_PAIR;
            ST_WAIT_PAIR: state_next = ST_CHECK_PAIR;
            ST_CHECK_PAIR:
            begin
                if (status.hit)
                begin
                    state_next = ST_DIVIDE;
                end
                else if (status.last_pair)
                begin
                    state_next = ST_OUTPUT;
                end
                else
                begin
                    state_next = ST_READ_PAIR;
                end
            end
            ST_DIVIDE:
            begin
                if (status.div_done)
                begin
                    state_next = ST_MULTIPLY;
                end
            end
            ST_MULTIPLY: state_next = ST_SCALE;
            ST_SCALE:    state_next = ST_OUTPUT;
            ST_OUTPUT:
            begin
                if (!out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // tracks that the last key answers the query
    logic last_rd_reg, last_rd_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_rd_reg <= 1'b0;
        end
        else
        begin
            last_rd_reg <= last_rd_next;
        end
    end

    always_comb
    begin
        last_rd_next = last_rd_reg;
        if (state_reg == ST_CHECK_PAIR && !status.hit && status.last_pair)
        begin
            last_rd_next = 1'b1;
        end
        else if (state_reg == ST_IDLE)
        begin
            last_rd_next = 1'b0;
        end
    end

    // outputs
    always_comb
    begin
        cmd = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready       = 1'b1;
                cmd.load_query = s_tvalid && s_cmd == CMD_QUERY;
            end
            ST_READ0: cmd.rd_first = 1'b1;
            ST_WAIT0: cmd.rd_pair = 1'b1;
            ST_CHECK0: cmd.rd_pair = 1'b1;
            ST_READ_PAIR: cmd.rd_pair = 1'b1;
            ST_WAIT_PAIR: cmd.rd_pair = 1'b1;
            ST_CHECK_PAIR:
            begin
                if (status.hit)
                begin
                    cmd.div_start = 1'b1;
                end
                else if (status.last_pair)
                begin
                    cmd.rd_last = 1'b1;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    cmd.rd_pair = 1'b1;
                end
            end
            ST_DIVIDE:   cmd.div_step = 1'b1;
            ST_MULTIPLY: cmd.mul_go   = 1'b1;
            ST_SCALE:    cmd.scale_go = 1'b1;
            ST_OUTPUT:
            begin
                cmd.load_out = !out_busy;
                if (last_rd_reg)
                begin
                    // hold the last-key read while the result waits
                    cmd.rd_last       = 1'b1;
                    cmd.which_case    = CASE_LAST;
                    cmd.out_from_lerp = 1'b0;
                end
                else if (status.single || status.before_first)
                begin
                    cmd.which_case    = CASE_FIRST;
                    cmd.out_from_lerp = 1'b0;
                end
                else
                begin
                    cmd.which_case    = CASE_INTERP;
                    cmd.out_from_lerp = 1'b1;
                end
            end
            default: cmd = '0;
        endcase
    end

endmodule

// ===== hw/rtl/kli_dp.sv =====
module kli_dp #(
    parameter int MAX_KEYS      = kli_pkg::MAX_KEYS_DEF,
    parameter int FRACTION_BITS = kli_pkg::FRACTION_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [kli_pkg::KEY_COUNT_W-1:0]   cfg_wdata,
    input  logic                              wr_en,
    input  logic [kli_pkg::KEY_INDEX_W-1:0]   wr_index,
    input  logic [kli_pkg::DATA_W-1:0]        wr_time,
    input  logic [kli_pkg::DATA_W-1:0]        wr_x,
    input  logic [kli_pkg::DATA_W-1:0]        wr_y,
    input  logic [kli_pkg::DATA_W-1:0]        wr_z,
    input  logic [kli_pkg::DATA_W-1:0]        query_time,
    input  kli_pkg::kli_cmd_t                 cmd,
    output kli_pkg::kli_status_t              status,
    input  logic                              m_tready,
    output logic                              m_tvalid,
    output logic [kli_pkg::DATA_W-1:0]        out_x,
    output logic [kli_pkg::DATA_W-1:0]        out_y,
    output logic [kli_pkg::DATA_W-1:0]        out_z,
    output logic [1:0]                        which_case,
    output logic                              out_busy
);
    import kli_pkg::*;

    localparam int AW  = $clog2(MAX_KEYS);
    localparam int CW  = $clog2(MAX_KEYS + 1);
    localparam int FW  = FRACTION_BITS + 1;
    localparam int NW  = DATA_W + FRACTION_BITS;
    localparam int DCW = $clog2(NW + 1);
    localparam int PW  = DATA_W + 1 + FW;

    // key count register, zero taken as one, saturated to table depth
    logic [KEY_COUNT_W-1:0] key_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_count_reg <= KEY_COUNT_W'(1);
        end
        else if (cfg_we)
        begin
            key_count_reg <= cfg_wdata;
        end
    end

    logic [CW-1:0] n_eff;
    always_comb
    begin
        if (key_count_reg == '0)
        begin
            n_eff = CW'(1);
        end
        else if (32'(key_count_reg) > MAX_KEYS)
        begin
            n_eff = CW'(MAX_KEYS);
        end
        else
        begin
            n_eff = CW'(key_count_reg);
        end
    end

    // query capture
    logic [DATA_W-1:0] q_reg;
    logic [CW-1:0]     n_reg;
    logic [AW-1:0]     idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            n_reg   <= CW'(1);
        end
        else if (cmd.load_query)
        begin
            idx_reg <= '0;
            n_reg   <= n_eff;
        end
        else if (cmd.advance)
        begin
            idx_reg <= idx_reg + AW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_query)
        begin
            q_reg <= query_time;
        end
    end

    // read addresses
    logic [AW-1:0] ra, rb, last_idx, idx_nx;
    logic          wr_ok;
    assign last_idx = AW'(n_reg - CW'(1));
    assign idx_nx   = cmd.advance ? idx_reg + AW'(1) : idx_reg;
    always_comb
    begin
        ra = idx_nx;
        rb = idx_nx + AW'(1);
        if (cmd.rd_first)
        begin
            ra = '0;
        end
        else if (cmd.rd_last)
        begin
            ra = last_idx;
        end
    end
    assign wr_ok = wr_en && (32'(wr_index) < MAX_KEYS);

    logic [DATA_W-1:0] t0, t1, x0, x1, y0, y1, z0, z1;

    kli_ram #(.WIDTH(DATA_W), .DEPTH(MAX_KEYS)) u_time (
        .clk, .we(wr_ok), .waddr(AW'(wr_index)), .wdata(wr_time),
        .raddr_a(ra), .rdata_a(t0), .raddr_b(rb), .rdata_b(t1));
    kli_ram #(.WIDTH(DATA_W), .DEPTH(MAX_KEYS)) u_x (
        .clk, .we(wr_ok), .waddr(AW'(wr_index)), .wdata(wr_x),
        .raddr_a(ra), .rdata_a(x0), .raddr_b(rb), .rdata_b(x1));
    kli_ram #(.WIDTH(DATA_W), .DEPTH(MAX_KEYS)) u_y (
        .clk, .we(wr_ok), .waddr(AW'(wr_index)), .wdata(wr_y),
        .raddr_a(ra), .rdata_a(y0), .raddr_b(rb), .rdata_b(y1));
    kli_ram #(.WIDTH(DATA_W), .DEPTH(MAX_KEYS)) u_z (
        .clk, .we(wr_ok), .waddr(AW'(wr_index)), .wdata(wr_z),
        .raddr_a(ra), .rdata_a(z0), .raddr_b(rb), .rdata_b(z1));

    // first-key check, latched while the first read is on port a
    logic bf_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.rd_pair && idx_reg == '0 && !cmd.advance)
        begin
            bf_reg <= (q_reg <= t0);
        end
    end

    assign status.single       = (n_reg == CW'(1));
    assign status.before_first = bf_reg;
    assign status.hit          = (t0 <= q_reg) && (q_reg <= t1);
    assign status.last_pair    = (CW'(idx_reg) + CW'(2) >= n_reg);

    // restoring divider, one quotient bit per cycle
    logic [NW-1:0]     num_reg;
    logic [DATA_W:0]   rem_reg;
    logic [DATA_W-1:0] den_reg;
    logic [DCW-1:0]    dcnt_reg;
    logic [DATA_W:0]   rem_sh, rem_sub;

    assign rem_sh  = {rem_reg[DATA_W-1:0], num_reg[NW-1]};
    assign rem_sub = rem_sh - {1'b0, den_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            num_reg  <= {q_reg - t0, {FRACTION_BITS{1'b0}}};
            den_reg  <= t1 - t0;
            rem_reg  <= '0;
            dcnt_reg <= DCW'(NW);
        end
        else if (cmd.div_step && dcnt_reg != '0)
        begin
            if (!rem_sub[DATA_W])
            begin
                rem_reg <= rem_sub;
                num_reg <= {num_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                num_reg <= {num_reg[NW-2:0], 1'b0};
            end
            dcnt_reg <= dcnt_reg - DCW'(1);
        end
    end

    assign status.div_done = (dcnt_reg == '0);

    // fraction, zero for equal key times
    logic [FW-1:0] frac;
    assign frac = (den_reg == '0) ? '0 : num_reg[FW-1:0];

    // products of differences and fraction
    logic signed [PW-1:0] px_reg, py_reg, pz_reg;
    logic signed [DATA_W:0] dx, dy, dz;
    assign dx = $signed({x1[DATA_W-1], x1}) - $signed({x0[DATA_W-1], x0});
    assign dy = $signed({y1[DATA_W-1], y1}) - $signed({y0[DATA_W-1], y0});
    assign dz = $signed({z1[DATA_W-1], z1}) - $signed({z0[DATA_W-1], z0});

    always_ff @(posedge clk)
    begin
        if (cmd.mul_go)
        begin
            px_reg <= PW'(dx) * $signed({1'b0, frac});
            py_reg <= PW'(dy) * $signed({1'b0, frac});
            pz_reg <= PW'(dz) * $signed({1'b0, frac});
        end
    end

    // arithmetic shift floors; add base value
    logic [DATA_W-1:0] rx_reg, ry_reg, rz_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.scale_go)
        begin
            rx_reg <= x0 + DATA_W'(px_reg >>> FRACTION_BITS);
            ry_reg <= y0 + DATA_W'(py_reg >>> FRACTION_BITS);
            rz_reg <= z0 + DATA_W'(pz_reg >>> FRACTION_BITS);
        end
    end

    // output register
    logic m_tvalid_reg;
    assign out_busy = m_tvalid_reg && !m_tready;
    assign m_tvalid = m_tvalid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            which_case <= cmd.which_case;
            if (cmd.out_from_lerp)
            begin
                out_x <= rx_reg;
                out_y <= ry_reg;
                out_z <= rz_reg;
            end
            else
            begin
                out_x <= x0;
                out_y <= y0;
                out_z <= z0;
            end
        end
    end

endmodule

// ===== hw/rtl/keyframe_linear_interpolator_top.sv =====
// Keyframe table with piecewise linear lookup. The command travels in s_tuser
// and the kind of answer in m_tuser. A write transaction stores one keyframe.
// A query transaction first reads key 0 and answers with it when only one key
// is in use or the query is at or before it. Otherwise it scans key pairs from
// the start, each pair through the read, wait and check states on the two read
// ports of the key memories; a query past every pair returns the last key in use.
// A hit runs a bit-serial divider for the fraction, then the multiply, scale and
// output states. One query is in flight at a time; s_tready stays low until the
// result is loaded into the output register, and a stalled result holds the
// block until m_tready frees that register.
module keyframe_linear_interpolator_top #(
    parameter int MAX_KEYS      = kli_pkg::MAX_KEYS_DEF,
    parameter int FRACTION_BITS = kli_pkg::FRACTION_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [6:0]   cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // key_index[5:0], key_time[37:6], key_x[69:38], key_y[101:70],
    // key_z[133:102], query_time[165:134], zero fill to 168
    input  logic [167:0] s_tdata,
    // cmd[0]
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_x[31:0], out_y[63:32], out_z[95:64]
    output logic [95:0]  m_tdata,
    // which_case[1:0]
    output logic [1:0]   m_tuser
);
    import kli_pkg::*;

    kli_cmd_t    cmd;
    kli_status_t status;
    logic        out_busy;
    logic [DATA_W-1:0] ox, oy, oz;
    logic [1:0]  wc;

    kli_ctrl u_ctrl (
        .clk, .rst_n, .s_tvalid, .s_cmd(s_tuser), .s_tready,
        .out_busy, .status, .cmd);

    kli_dp #(.MAX_KEYS(MAX_KEYS), .FRACTION_BITS(FRACTION_BITS)) u_dp (
        .clk, .rst_n, .cfg_we, .cfg_wdata,
        .wr_en(s_tvalid && s_tready && s_tuser == CMD_WRITE),
        .wr_index(s_tdata[5:0]), .wr_time(s_tdata[37:6]),
        .wr_x(s_tdata[69:38]), .wr_y(s_tdata[101:70]), .wr_z(s_tdata[133:102]),
        .query_time(s_tdata[165:134]), .cmd, .status, .m_tready, .m_tvalid,
        .out_x(ox), .out_y(oy), .out_z(oz), .which_case(wc), .out_busy);

    assign m_tdata = {oz, oy, ox};
    assign m_tuser = wc;

endmodule

// ===== tb/sv/keyframe_linear_interpolator_checker.sv =====
`timescale 1ns / 1ps

module keyframe_linear_interpolator_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [6:0]   cfg_wdata,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [167:0] s_tdata,
    input  logic         s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [95:0]  m_tdata,
    input  logic [1:0]   m_tuser,
    output int           fail_count,
    output int           pending_count
);
    import kli_pkg::*;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [1:0]  wc;
    } point_t;

    logic [31:0] key_time_mem [64];
    logic [31:0] key_x_mem [64];
    logic [31:0] key_y_mem [64];
    logic [31:0] key_z_mem [64];
    logic [6:0]  key_count_reg;
    point_t      expected_points [$];

    // blend one component: v0 + floor((v1 - v0) * f / 2^16)
    function automatic logic [31:0] blend(logic [31:0] a, logic [31:0] b, longint f);
        longint va;
        longint d;
        longint p;
        va = longint'($signed(a));
        d  = longint'($signed(b)) - va;
        p  = d * f;
        return 32'(va + (p >>> FRACTION_BITS_DEF));
    endfunction

    function automatic point_t lookup_point(logic [31:0] q);
        int          n;
        point_t      r;
        logic [31:0] t0;
        logic [31:0] t1;
        longint      f;
        n = int'(key_count_reg);
        if (n < 1)
            n = 1;
        if (n > MAX_KEYS_DEF)
            n = MAX_KEYS_DEF;
        if (n == 1 || q <= key_time_mem[0])
        begin
            r = '{key_x_mem[0], key_y_mem[0], key_z_mem[0], CASE_FIRST};
            return r;
        end
        for (int i = 0; i + 1 < n; i++)
        begin
            t0 = key_time_mem[i];
            t1 = key_time_mem[i + 1];
            if (t0 <= q && q <= t1)
            begin
                f = 0;
                if (t1 != t0)
                    f = longint'({32'd0, q - t0} << FRACTION_BITS_DEF) /
                        longint'({32'd0, t1 - t0});
                r.x  = blend(key_x_mem[i], key_x_mem[i + 1], f);
                r.y  = blend(key_y_mem[i], key_y_mem[i + 1], f);
                r.z  = blend(key_z_mem[i], key_z_mem[i + 1], f);
                r.wc = CASE_INTERP;
                return r;
            end
        end
        r = '{key_x_mem[n - 1], key_y_mem[n - 1], key_z_mem[n - 1], CASE_LAST};
        return r;
    endfunction

    assign pending_count = expected_points.size();

    // track config, stored keys and outgoing transactions
    always @(posedge clk or negedge rst_n)
    begin
        point_t exp_p;
        point_t got_p;
        logic [5:0] idx;
        if (!rst_n)
        begin
            fail_count    = 0;
            key_count_reg = 7'd1;
            expected_points.delete();
            for (int i = 0; i < 64; i++)
            begin
                key_time_mem[i] = '0;
                key_x_mem[i]    = '0;
                key_y_mem[i]    = '0;
                key_z_mem[i]    = '0;
            end
        end
        else
        begin
            if (cfg_we)
                key_count_reg = cfg_wdata;
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == CMD_WRITE)
                begin
                    idx = s_tdata[5:0];
                    key_time_mem[idx] = s_tdata[37:6];
                    key_x_mem[idx]    = s_tdata[69:38];
                    key_y_mem[idx]    = s_tdata[101:70];
                    key_z_mem[idx]    = s_tdata[133:102];
                end
                else
                    expected_points = {expected_points, lookup_point(s_tdata[165:134])};
            end
            if (m_tvalid && m_tready)
            begin
                got_p = '{m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tuser};
                if (expected_points.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result transaction, actual %h", $time, got_p);
                end
                else
                begin
                    exp_p = expected_points.pop_front();
                    if (got_p.x !== exp_p.x)
                    begin
                        fail_count++;
                        $display("%0t: out_x expected %h actual %h", $time, exp_p.x, got_p.x);
                    end
                    if (got_p.y !== exp_p.y)
                    begin
                        fail_count++;
                        $display("%0t: out_y expected %h actual %h", $time, exp_p.y, got_p.y);
                    end
                    if (got_p.z !== exp_p.z)
                    begin
                        fail_count++;
                        $display("%0t: out_z expected %h actual %h", $time, exp_p.z, got_p.z);
                    end
                    if (got_p.wc !== exp_p.wc)
                    begin
                        fail_count++;
                        $display("%0t: which_case expected %0d actual %0d", $time,
                                 exp_p.wc, got_p.wc);
                    end
                end
            end
        end
    end

endmodule

// ===== tb/sv/keyframe_linear_interpolator_top_tb.sv =====
`timescale 1ns / 1ps

module keyframe_linear_interpolator_top_tb;
    import kli_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_CYCLES = 300;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [6:0]   cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [167:0] s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [95:0]  m_tdata;
    logic [1:0]   m_tuser;
    int           fail_count;
    int           pending_count;
    int           cycle_count;
    int           items_sent;
    int           ready_hold;
    int           active_keys;
    logic [31:0]  key_times [64];

    keyframe_linear_interpolator_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    keyframe_linear_interpolator_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // result side backpressure: bursts of ready, short and long stalls
    initial
    begin
        m_tready   = 1'b0;
        ready_hold = 0;
        forever
        begin
            @(posedge clk);
            if (ready_hold > 0)
                ready_hold--;
            else
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4:
                    begin
                        m_tready   <= 1'b1;
                        ready_hold = $urandom_range(1, 20);
                    end
                    9:
                    begin
                        m_tready   <= 1'b0;
                        ready_hold = $urandom_range(20, 60);
                    end
                    default:
                    begin
                        m_tready   <= 1'b0;
                        ready_hold = $urandom_range(1, 3);
                    end
                endcase
            end
        end
    end

    // one transaction on the input side, after a random gap
    task automatic send_item(logic cmd, logic [5:0] idx, logic [31:0] t, logic [31:0] x,
                             logic [31:0] y, logic [31:0] z, logic [31:0] q);
        int gap;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: gap = 0;
            9:             gap = $urandom_range(10, 40);
            default:       gap = $urandom_range(1, 3);
        endcase
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b0, q, z, y, x, t, idx};
        s_tuser  <= cmd;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic write_key(logic [5:0] idx, logic [31:0] t, logic [31:0] x,
                             logic [31:0] y, logic [31:0] z);
        key_times[idx] = t;
        send_item(CMD_WRITE, idx, t, x, y, z, $urandom);
    endtask

    task automatic query_at(logic [31:0] q);
        send_item(CMD_QUERY, 6'($urandom), $urandom, $urandom, $urandom, $urandom, q);
    endtask

    // register write once the block has drained
    task automatic set_key_count(logic [6:0] val);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (val == 0)
            active_keys = 1;
        else if (val > 64)
            active_keys = 64;
        else
            active_keys = int'(val);
    endtask

    // fill slots 0..active_keys-1: sorted, sorted with repeats, or scrambled
    task automatic load_table();
        int          style;
        logic [31:0] t;
        style = $urandom_range(0, 9);
        t = $urandom_range(0, 32'h1000_0000);
        for (int i = 0; i < active_keys; i++)
        begin
            if (style == 9)
                t = $urandom;
            else if (i > 0)
            begin
                if (style >= 7 && $urandom_range(0, 3) == 0)
                    t = t;
                else if ($urandom_range(0, 4) == 0)
                    t = t + $urandom_range(1, 32'h0200_0000);
                else
                    t = t + $urandom_range(1, 32'h0004_0000);
            end
            write_key(6'(i), t, $urandom, $urandom, $urandom);
        end
    endtask

    function automatic logic [31:0] pick_query();
        int          i;
        logic [31:0] lo;
        logic [31:0] hi;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5:
            begin
                i  = (active_keys > 1) ? $urandom_range(0, active_keys - 2) : 0;
                lo = key_times[i];
                hi = key_times[(active_keys > 1) ? i + 1 : 0];
                if (lo <= hi)
                    return lo + $urandom_range(0, hi - lo);
                return $urandom_range(hi, lo);
            end
            6: return key_times[$urandom_range(0, active_keys - 1)];
            7, 8: return $urandom;
            default:
            begin
                case ($urandom_range(0, 2))
                    0: return 32'd0;
                    1: return 32'hFFFF_FFFF;
                    default: return key_times[0] + 1;
                endcase
            end
        endcase
    endfunction

    initial
    begin
        int r;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = 1'b0;
        items_sent  = 0;
        active_keys = 1;
        for (int i = 0; i < 64; i++)
            key_times[i] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: single key after reset, extremes of values
        write_key(6'd0, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
        query_at(32'd0);
        query_at(32'hFFFF_FFFF);

        // two keys: interior, both ends, past the end
        set_key_count(7'd2);
        write_key(6'd1, 32'h0003_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        query_at(32'h0002_0000);
        query_at(32'h0001_0000);
        query_at(32'h0003_0000);
        query_at(32'h0001_0001);
        query_at(32'hFFFF_FFFF);

        // repeated key time inside the table and a top slot write
        set_key_count(7'd3);
        write_key(6'd2, 32'h0003_0000, 32'h1234_5678, 32'hDEAD_BEEF, 32'h0000_0001);
        write_key(6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF);
        query_at(32'h0003_0000);
        query_at(32'h0004_0000);

        // key count of zero behaves as one
        set_key_count(7'd0);
        query_at(32'h0005_0000);

        // full table, then a count above the table size
        set_key_count(7'd64);
        load_table();
        query_at(32'hFFFF_FFFF);
        query_at(key_times[63]);
        set_key_count(7'd127);
        query_at(32'hFFFF_FFFF);
        query_at(pick_query());

        // random phases, each with its own key count
        while (items_sent < 750)
        begin
            r = $urandom_range(0, 19);
            case (r)
                0: set_key_count(7'd0);
                1: set_key_count(7'd127);
                2: set_key_count(7'd64);
                3, 4: set_key_count(7'd1);
                5, 6: set_key_count(7'd2);
                17, 18, 19: set_key_count(7'($urandom_range(9, 63)));
                default: set_key_count(7'($urandom_range(3, 8)));
            endcase
            load_table();
            repeat ($urandom_range(20, 40))
            begin
                if ($urandom_range(0, 9) < 8)
                    query_at(pick_query());
                else
                    write_key(6'($urandom), $urandom, $urandom, $urandom, $urandom);
            end
        end

        // drain
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
